FILE: rtl/core/skf_pkg.sv
`default_nettype none

package skf_pkg;

    localparam int DATA_W     = 32;
    localparam int UDATA_W    = 31;
    localparam int PROD_W     = 48;
    localparam int ACC_W      = 50;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_W     = 16;
    localparam int MUL_CNT_W  = 5;
    localparam int DIV_STEPS  = DATA_W + FRAC_W;
    localparam int DIV_CNT_W  = 6;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_GAIN         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GAIN           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_VARIANCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSERVATION_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_VARIANCE = 3'd5;

    // Reset values, Q16.16.
    localparam logic signed [DATA_W-1:0] TRANSITION_GAIN_RST      = 32'sd65536;
    localparam logic signed [DATA_W-1:0] CONTROL_GAIN_RST         = 32'sd0;
    localparam logic signed [DATA_W-1:0] NOISE_GAIN_RST           = 32'sd6554;
    localparam logic [UDATA_W-1:0]       PROCESS_VARIANCE_RST     = 31'd6554;
    localparam logic signed [DATA_W-1:0] OBSERVATION_GAIN_RST     = 32'sd65536;
    localparam logic [UDATA_W-1:0]       MEASUREMENT_VARIANCE_RST = 31'd6554;
    localparam logic signed [DATA_W-1:0] ESTIMATE_RST             = 32'sd0;
    localparam logic [UDATA_W-1:0]       COVARIANCE_RST           = 31'd327680;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic [UDATA_W-1:0]       U31_MAX = 31'h7FFF_FFFF;
    localparam logic signed [ACC_W-1:0]  ACC_S32_MAX = 50'sd2147483647;
    localparam logic signed [ACC_W-1:0]  ACC_S32_MIN = -50'sd2147483648;
    localparam logic [PROD_W-1:0]        QUO_POS_LIM = 48'h0000_7FFF_FFFF;
    localparam logic [PROD_W-1:0]        QUO_NEG_LIM = 48'h0000_8000_0000;

    // Sequencer steps, one product each.
    localparam logic [STEP_W-1:0] STEP_FX    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DU    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_FP    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_BQ    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FPF   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_BQB   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CC    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_S     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_P     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_INNOV = 4'd9;
    localparam logic [STEP_W-1:0] STEP_X     = 4'd10;

    typedef enum logic [3:0] {
        OPND_F,
        OPND_D,
        OPND_B,
        OPND_Q,
        OPND_H,
        OPND_X,
        OPND_U,
        OPND_P,
        OPND_FP,
        OPND_BQ,
        OPND_P1,
        OPND_CC,
        OPND_G,
        OPND_X1,
        OPND_INNOV
    } opnd_t;

    typedef enum logic [2:0] {
        ADD_ZERO,
        ADD_ACC,
        ADD_R,
        ADD_Z,
        ADD_X1,
        ADD_P1
    } addend_t;

    typedef enum logic [3:0] {
        DST_ACC,
        DST_X1,
        DST_FP,
        DST_BQ,
        DST_P1,
        DST_CC,
        DST_S,
        DST_P,
        DST_INNOV,
        DST_X
    } dest_t;

    typedef struct packed {
        opnd_t   a_sel;
        opnd_t   b_sel;
        addend_t add_sel;
        logic    neg;
        dest_t   dst;
    } step_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic              in_ready;
        logic              mul_start;
        logic              div_start;
        logic              wb;
        logic              load_out;
        logic [STEP_W-1:0] step;
    } seq_ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic mul_done;
        logic div_done;
        logic out_free;
    } seq_stat_t;

    function automatic step_ctrl_t step_decode(input logic [STEP_W-1:0] step);
        step_ctrl_t c;
        c = '{a_sel: OPND_F, b_sel: OPND_X, add_sel: ADD_ZERO, neg: 1'b0, dst: DST_ACC};
        unique case (step)
            STEP_FX:    c = '{a_sel: OPND_F,  b_sel: OPND_X,     add_sel: ADD_ZERO,
                              neg: 1'b0, dst: DST_ACC};
            STEP_DU:    c = '{a_sel: OPND_D,  b_sel: OPND_U,     add_sel: ADD_ACC,
                              neg: 1'b0, dst: DST_X1};
            STEP_FP:    c = '{a_sel: OPND_F,  b_sel: OPND_P,     add_sel: ADD_ZERO,
                              neg: 1'b0, dst: DST_FP};
            STEP_BQ:    c = '{a_sel: OPND_B,  b_sel: OPND_Q,     add_sel: ADD_ZERO,
                              neg: 1'b0, dst: DST_BQ};
            STEP_FPF:   c = '{a_sel: OPND_FP, b_sel: OPND_F,     add_sel: ADD_ZERO,
                              neg: 1'b0, dst: DST_ACC};
            STEP_BQB:   c = '{a_sel: OPND_BQ, b_sel: OPND_B,     add_sel: ADD_ACC,
                              neg: 1'b0, dst: DST_P1};
            STEP_CC:    c = '{a_sel: OPND_P1, b_sel: OPND_H,     add_sel: ADD_ZERO,
                              neg: 1'b0, dst: DST_CC};
            STEP_S:     c = '{a_sel: OPND_CC, b_sel: OPND_H,     add_sel: ADD_R,
                              neg: 1'b0, dst: DST_S};
            STEP_P:     c = '{a_sel: OPND_G,  b_sel: OPND_CC,    add_sel: ADD_P1,
                              neg: 1'b1, dst: DST_P};
            STEP_INNOV: c = '{a_sel: OPND_H,  b_sel: OPND_X1,    add_sel: ADD_Z,
                              neg: 1'b1, dst: DST_INNOV};
            STEP_X:     c = '{a_sel: OPND_G,  b_sel: OPND_INNOV, add_sel: ADD_X1,
                              neg: 1'b0, dst: DST_X};
            default:    c = '{a_sel: OPND_F,  b_sel: OPND_X,     add_sel: ADD_ZERO,
                              neg: 1'b0, dst: DST_ACC};
        endcase
        return c;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > ACC_S32_MAX) begin
            r = S32_MAX;
        end else if (v < ACC_S32_MIN) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [UDATA_W-1:0] sat_u31(input logic signed [ACC_W-1:0] v);
        logic [UDATA_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ACC_S32_MAX) begin
            r = U31_MAX;
        end else begin
            r = v[UDATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v[DATA_W-1]) begin
            r = ~v + 32'd1;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/skf_mul.sv
`default_nettype none

module skf_mul (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [skf_pkg::DATA_W-1:0]   a,
    input  wire logic signed [skf_pkg::DATA_W-1:0]   b,
    output logic                                     done,
    output logic signed [skf_pkg::PROD_W-1:0]        prod
);
    import skf_pkg::*;

    localparam logic [MUL_CNT_W-1:0] LAST_BIT = MUL_CNT_W'(DATA_W - 1);

    logic signed [DATA_W:0]        hi_reg, hi_next;
    logic [DATA_W-1:0]             lo_reg, lo_next;
    logic signed [DATA_W-1:0]      mcand_reg, mcand_next;
    logic [MUL_CNT_W-1:0]          cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          rnd_reg, rnd_next;
    logic                          done_reg, done_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;

    logic signed [DATA_W+1:0]      mc_ext;
    logic signed [DATA_W+1:0]      addend;
    logic signed [DATA_W+1:0]      sum;
    logic [2*DATA_W-1:0]           full;

    // One multiplier bit per cycle; the sign bit of the multiplier carries
    // negative weight, so its partial product is subtracted.
    always_comb
    begin
        mc_ext = (DATA_W+2)'(mcand_reg);
        if (!lo_reg[0]) begin
            addend = '0;
        end else if (cnt_reg == LAST_BIT) begin
            addend = -mc_ext;
        end else begin
            addend = mc_ext;
        end
        sum  = (DATA_W+2)'(hi_reg) + addend;
        full = {hi_reg[DATA_W-1:0], lo_reg};
    end

    always_comb
    begin
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        rnd_next   = 1'b0;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        if (start) begin
            hi_next    = '0;
            lo_next    = b;
            mcand_next = a;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            hi_next  = sum[DATA_W+1:1];
            lo_next  = {sum[0], lo_reg[DATA_W-1:1]};
            cnt_next = cnt_reg + MUL_CNT_W'(1);
            if (cnt_reg == LAST_BIT) begin
                busy_next = 1'b0;
                rnd_next  = 1'b1;
            end
        end else if (rnd_reg) begin
            // Round half up: floor((p + 2^15) / 2^16) equals (p >>> 16) + p[15].
            prod_next = full[2*DATA_W-1:FRAC_W] + PROD_W'(full[FRAC_W-1]);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: rtl/core/skf_div.sv
`default_nettype none

module skf_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [skf_pkg::DATA_W-1:0]   num,
    input  wire logic signed [skf_pkg::DATA_W-1:0]   den,
    output logic                                     done,
    output logic signed [skf_pkg::DATA_W-1:0]        quot
);
    import skf_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    logic [PROD_W-1:0]          nq_reg, nq_next;
    logic [DATA_W-1:0]          rem_reg, rem_next;
    logic [DATA_W-1:0]          dvs_reg, dvs_next;
    logic                       neg_reg, neg_next;
    logic                       zero_reg, zero_next;
    logic [DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       fin_reg, fin_next;
    logic                       done_reg, done_next;
    logic signed [DATA_W-1:0]   quot_reg, quot_next;

    logic [DATA_W:0]            shifted;
    logic [DATA_W+1:0]          diff;
    logic                       take;

    // Restoring division on magnitudes, one quotient bit per cycle. The
    // quotient bits shift into the low end of the numerator register.
    always_comb
    begin
        shifted = {rem_reg, nq_reg[PROD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        take    = !diff[DATA_W+1];
    end

    always_comb
    begin
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (start) begin
            nq_next   = {abs32(num), {FRAC_W{1'b0}}};
            rem_next  = '0;
            dvs_next  = abs32(den);
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
            zero_next = (den == '0);
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            nq_next  = {nq_reg[PROD_W-2:0], take};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            // A zero denominator gives zero gain.
            if (zero_reg) begin
                quot_next = '0;
            end else if (!neg_reg) begin
                quot_next = (nq_reg > QUO_POS_LIM) ? S32_MAX : nq_reg[DATA_W-1:0];
            end else begin
                quot_next = (nq_reg > QUO_NEG_LIM) ? S32_MIN : -nq_reg[DATA_W-1:0];
            end
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg   <= nq_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

FILE: rtl/core/skf_seq.sv
`default_nettype none

module skf_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire skf_pkg::seq_stat_t   stat,
    output skf_pkg::seq_ctrl_t        ctrl
);
    import skf_pkg::*;

    seq_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_fire) begin
                    state_next = ST_MUL_GO;
                    step_next  = STEP_FX;
                end
            end
            ST_MUL_GO:
            begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (stat.mul_done) begin
                    if (step_reg == STEP_X) begin
                        state_next = ST_DONE;
                    end else begin
                        step_next  = step_reg + STEP_W'(1);
                        // The gain division runs right after the innovation variance.
                        state_next = (step_reg == STEP_S) ? ST_DIV_GO : ST_MUL_GO;
                    end
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done) begin
                    state_next = ST_MUL_GO;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.in_ready  = 1'b0;
        ctrl.mul_start = 1'b0;
        ctrl.div_start = 1'b0;
        ctrl.wb        = 1'b0;
        ctrl.load_out  = 1'b0;
        ctrl.step      = step_reg;
        unique case (state_reg)
            ST_IDLE:     ctrl.in_ready  = 1'b1;
            ST_MUL_GO:   ctrl.mul_start = 1'b1;
            ST_MUL_WAIT: ctrl.wb        = stat.mul_done;
            ST_DIV_GO:   ctrl.div_start = 1'b1;
            ST_DIV_WAIT: ctrl.wb        = 1'b0;
            ST_DONE:     ctrl.load_out  = stat.out_free;
            default:     ctrl.in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_FX;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/scalar_kalman_filter_top.sv
`default_nettype none

// in_ready is high only while idle: a new input transaction is taken only after the
// previous result has been loaded into the output register. Eleven Q16.16 products go
// one at a time through a bit-serial multiplier and the gain through a 48-step
// restoring divider. A finished result waits in the output register.
// Reset (async, active low) loads the default coefficients, clears the
// estimate and sets the covariance to 5.0.

module scalar_kalman_filter_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [skf_pkg::DATA_W-1:0]    measurement,
    input  wire logic signed [skf_pkg::DATA_W-1:0]    control_value,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [skf_pkg::DATA_W-1:0]         estimate,
    output logic signed [skf_pkg::DATA_W-1:0]         kalman_gain,
    output logic [skf_pkg::UDATA_W-1:0]               covariance,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]           cfg_data
);
    import skf_pkg::*;

    logic signed [DATA_W-1:0]   transition_gain_reg;
    logic signed [DATA_W-1:0]   control_gain_reg;
    logic signed [DATA_W-1:0]   noise_gain_reg;
    logic [UDATA_W-1:0]         process_variance_reg;
    logic signed [DATA_W-1:0]   observation_gain_reg;
    logic [UDATA_W-1:0]         measurement_variance_reg;

    logic signed [DATA_W-1:0]   x_reg;
    logic [UDATA_W-1:0]         p_reg;

    logic signed [DATA_W-1:0]   z_reg, u_reg;
    logic signed [DATA_W-1:0]   x1_reg, fp_reg, bq_reg, p1_reg, cc_reg, s_reg;
    logic signed [DATA_W-1:0]   g_reg, innov_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic                       out_valid_reg;
    logic signed [DATA_W-1:0]   estimate_reg, kalman_gain_reg;
    logic [UDATA_W-1:0]         covariance_reg;

    seq_ctrl_t                  ctrl;
    seq_stat_t                  stat;
    step_ctrl_t                 sc;

    logic                       in_fire, cfg_fire;
    logic signed [DATA_W-1:0]   a_op, b_op;
    logic                       mul_done, div_done;
    logic signed [PROD_W-1:0]   mul_prod;
    logic signed [DATA_W-1:0]   div_quot;
    logic signed [ACC_W-1:0]    addend_val, prod_ext, sum_val;
    logic signed [DATA_W-1:0]   sum_sat;
    logic [UDATA_W-1:0]         sum_clamp;

    assign in_fire   = in_valid & ctrl.in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    assign stat.in_fire  = in_fire;
    assign stat.mul_done = mul_done;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    skf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign sc = step_decode(ctrl.step);

    always_comb
    begin
        case (sc.a_sel)
            OPND_F:     a_op = transition_gain_reg;
            OPND_D:     a_op = control_gain_reg;
            OPND_B:     a_op = noise_gain_reg;
            OPND_Q:     a_op = {1'b0, process_variance_reg};
            OPND_H:     a_op = observation_gain_reg;
            OPND_X:     a_op = x_reg;
            OPND_U:     a_op = u_reg;
            OPND_P:     a_op = {1'b0, p_reg};
            OPND_FP:    a_op = fp_reg;
            OPND_BQ:    a_op = bq_reg;
            OPND_P1:    a_op = p1_reg;
            OPND_CC:    a_op = cc_reg;
            OPND_G:     a_op = g_reg;
            OPND_X1:    a_op = x1_reg;
            OPND_INNOV: a_op = innov_reg;
            default:    a_op = '0;
        endcase
        case (sc.b_sel)
            OPND_F:     b_op = transition_gain_reg;
            OPND_D:     b_op = control_gain_reg;
            OPND_B:     b_op = noise_gain_reg;
            OPND_Q:     b_op = {1'b0, process_variance_reg};
            OPND_H:     b_op = observation_gain_reg;
            OPND_X:     b_op = x_reg;
            OPND_U:     b_op = u_reg;
            OPND_P:     b_op = {1'b0, p_reg};
            OPND_FP:    b_op = fp_reg;
            OPND_BQ:    b_op = bq_reg;
            OPND_P1:    b_op = p1_reg;
            OPND_CC:    b_op = cc_reg;
            OPND_G:     b_op = g_reg;
            OPND_X1:    b_op = x1_reg;
            OPND_INNOV: b_op = innov_reg;
            default:    b_op = '0;
        endcase
    end

    skf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.mul_start),
        .a     (a_op),
        .b     (b_op),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    skf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (cc_reg),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Each step adds its rounded product (or subtracts it) to an exact sum and
    // saturates only when the result is written to its register.
    always_comb
    begin
        case (sc.add_sel)
            ADD_ZERO: addend_val = '0;
            ADD_ACC:  addend_val = acc_reg;
            ADD_R:    addend_val = {{(ACC_W-UDATA_W){1'b0}}, measurement_variance_reg};
            ADD_Z:    addend_val = ACC_W'(z_reg);
            ADD_X1:   addend_val = ACC_W'(x1_reg);
            ADD_P1:   addend_val = ACC_W'(p1_reg);
            default:  addend_val = '0;
        endcase
        prod_ext  = ACC_W'(mul_prod);
        sum_val   = addend_val + (sc.neg ? -prod_ext : prod_ext);
        sum_sat   = sat_s32(sum_val);
        sum_clamp = sat_u31(sum_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            transition_gain_reg      <= TRANSITION_GAIN_RST;
            control_gain_reg         <= CONTROL_GAIN_RST;
            noise_gain_reg           <= NOISE_GAIN_RST;
            process_variance_reg     <= PROCESS_VARIANCE_RST;
            observation_gain_reg     <= OBSERVATION_GAIN_RST;
            measurement_variance_reg <= MEASUREMENT_VARIANCE_RST;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                CFG_TRANSITION_GAIN:      transition_gain_reg      <= cfg_data;
                CFG_CONTROL_GAIN:         control_gain_reg         <= cfg_data;
                CFG_NOISE_GAIN:           noise_gain_reg           <= cfg_data;
                CFG_PROCESS_VARIANCE:     process_variance_reg     <= cfg_data[UDATA_W-1:0];
                CFG_OBSERVATION_GAIN:     observation_gain_reg     <= cfg_data;
                CFG_MEASUREMENT_VARIANCE: measurement_variance_reg <= cfg_data[UDATA_W-1:0];
                default:                  transition_gain_reg      <= transition_gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            x_reg <= ESTIMATE_RST;
            p_reg <= COVARIANCE_RST;
        end else if (ctrl.wb) begin
            if (sc.dst == DST_X) begin
                x_reg <= sum_sat;
            end
            if (sc.dst == DST_P) begin
                p_reg <= sum_clamp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            z_reg <= measurement;
            u_reg <= control_value;
        end
        if (div_done) begin
            g_reg <= div_quot;
        end
        if (ctrl.wb) begin
            acc_reg <= sum_val;
            case (sc.dst)
                DST_X1:    x1_reg    <= sum_sat;
                DST_FP:    fp_reg    <= sum_sat;
                DST_BQ:    bq_reg    <= sum_sat;
                DST_P1:    p1_reg    <= sum_sat;
                DST_CC:    cc_reg    <= sum_sat;
                DST_S:     s_reg     <= sum_sat;
                DST_INNOV: innov_reg <= sum_sat;
                default:   innov_reg <= innov_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out) begin
            estimate_reg    <= x_reg;
            kalman_gain_reg <= g_reg;
            covariance_reg  <= p_reg;
        end
    end

    assign in_ready    = ctrl.in_ready;
    assign out_valid   = out_valid_reg;
    assign estimate    = estimate_reg;
    assign kalman_gain = kalman_gain_reg;
    assign covariance  = covariance_reg;

endmodule

`default_nettype wire
